// File: sv/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int ValueWidth   = 32;
  localparam int MaxDigits    = 32;
  localparam int RadixWidth   = 6;
  localparam int CharWidth    = 8;
  localparam int DigCntWidth  = $clog2(MaxDigits + 1);
  localparam int DigAddrWidth = $clog2(MaxDigits);
  localparam int DivCntWidth  = $clog2(ValueWidth);

  localparam logic [CharWidth-1:0] ChZero      = 8'd48;
  localparam logic [CharWidth-1:0] ChAlphaBase = 8'd55;
  localparam logic [CharWidth-1:0] ChMinus     = 8'd45;
  localparam logic [CharWidth-1:0] ChCr        = 8'd13;
  localparam logic [CharWidth-1:0] ChLf        = 8'd10;
  localparam logic [CharWidth-1:0] ChNull      = 8'd0;

  localparam logic [RadixWidth-1:0] RadixRaw = 6'd0;
  localparam logic [RadixWidth-1:0] RadixBad = 6'd1;
  localparam logic [RadixWidth-1:0] RadixDec = 6'd10;

  typedef enum logic [3:0] {
    StIdle,
    StBad,
    StRaw,
    StSign,
    StStart,
    StDiv,
    StPop,
    StDigit,
    StCr,
    StLf
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [ValueWidth-1:0] dividend;
    logic [RadixWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [ValueWidth-1:0] quotient;
    logic [RadixWidth-1:0] remainder;
  } div_rsp_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [RadixWidth-1:0] d);
    logic [CharWidth-1:0] dx;
    dx = CharWidth'(d);
    return (d < RadixDec) ? (dx + ChZero) : (dx + ChAlphaBase);
  endfunction

endpackage

// File: sv/itoa_if.sv
// ----------------------------------------------------------------------------
// itoa_if
// Valid/ready channels for the number words in and the character words out.
// ----------------------------------------------------------------------------
interface itoa_in_if;
  logic                              valid;
  logic                              ready;
  logic [itoa_pkg::ValueWidth-1:0]   value;
  logic                              is_signed;
  logic [itoa_pkg::RadixWidth-1:0]   radix;
  logic                              append_newline;

  modport source (output valid, value, is_signed, radix, append_newline, input ready);
  modport sink   (input valid, value, is_signed, radix, append_newline, output ready);
endinterface

interface itoa_out_if;
  logic                            valid;
  logic                            ready;
  logic [itoa_pkg::CharWidth-1:0]  char_out;
  logic                            last;
  logic                            bad_radix;

  modport source (output valid, char_out, last, bad_radix, input ready);
  modport sink   (input valid, char_out, last, bad_radix, output ready);
endinterface

// File: sv/itoa_div.sv
// ----------------------------------------------------------------------------
// itoa_div
// Restoring divider, one quotient bit per cycle, shared by all digits.
// ----------------------------------------------------------------------------
module itoa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  itoa_pkg::div_req_t req_i,
  output itoa_pkg::div_rsp_t rsp_o
);

  localparam int RemWidth = itoa_pkg::RadixWidth + 1;

  logic [itoa_pkg::ValueWidth-1:0]  quo_q, quo_d;
  logic [itoa_pkg::RadixWidth-1:0]  rem_q, rem_d;
  logic [itoa_pkg::RadixWidth-1:0]  dvs_q;
  logic [itoa_pkg::DivCntWidth-1:0] cnt_q, cnt_d;
  logic                             busy_q, busy_d;
  logic                             done_q, done_d;

  logic [RemWidth-1:0]             rem_shift;
  logic [itoa_pkg::RadixWidth-1:0] rem_diff;
  logic                            rem_ge;
  logic                            cnt_end;

  assign rem_shift = {rem_q, quo_q[itoa_pkg::ValueWidth-1]};
  assign rem_diff  = rem_shift[itoa_pkg::RadixWidth-1:0] - dvs_q;
  assign rem_ge    = rem_shift >= {1'b0, dvs_q};
  assign cnt_end   = cnt_q == itoa_pkg::DivCntWidth'(itoa_pkg::ValueWidth - 1);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[itoa_pkg::ValueWidth-2:0], rem_ge};
      rem_d = rem_ge ? rem_diff
                     : rem_shift[itoa_pkg::RadixWidth-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_end) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: sv/itoa_seq.sv
// ----------------------------------------------------------------------------
// itoa_seq
// Sequencer: takes a number word, drives the divider, stacks the digits and
// emits the character words through an output register.
// ----------------------------------------------------------------------------
module itoa_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  itoa_in_if.sink            in_i,
  itoa_out_if.source         out_o,
  output itoa_pkg::div_req_t div_req_o,
  input  itoa_pkg::div_rsp_t div_rsp_i
);

  itoa_pkg::state_e state_q, state_d;

  logic [itoa_pkg::ValueWidth-1:0]  val_q;
  logic [itoa_pkg::RadixWidth-1:0]  radix_q;
  logic                             nl_q;
  logic [itoa_pkg::DigCntWidth-1:0] nd_q;
  logic [itoa_pkg::DigCntWidth-1:0] nd_dec;
  logic [itoa_pkg::RadixWidth-1:0]  dig_mem [itoa_pkg::MaxDigits];
  logic [itoa_pkg::RadixWidth-1:0]  rd_q;

  logic [itoa_pkg::CharWidth-1:0] char_q;
  logic                           last_q;
  logic                           bad_q;
  logic                           oval_q;

  logic                           accept;
  logic                           is_neg;
  logic [itoa_pkg::ValueWidth-1:0] mag;
  logic                           out_free;
  logic                           more_div;

  logic                           in_rdy;
  logic                           emit;
  logic [itoa_pkg::CharWidth-1:0] emit_char;
  logic                           emit_last;
  logic                           emit_bad;
  logic                           push;
  logic                           pop;
  logic                           div_start;

  assign accept   = in_i.valid && in_rdy;
  assign is_neg   = (in_i.radix == itoa_pkg::RadixDec) && in_i.is_signed
                    && in_i.value[itoa_pkg::ValueWidth-1];
  assign mag      = is_neg ? (~in_i.value + 1'b1) : in_i.value;
  assign out_free = !oval_q || out_o.ready;
  assign nd_dec   = nd_q - 1'b1;
  assign more_div = (div_rsp_i.quotient != '0)
                    && (nd_q != itoa_pkg::DigCntWidth'(itoa_pkg::MaxDigits - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itoa_pkg::StIdle: begin
        if (accept) begin
          if (in_i.radix == itoa_pkg::RadixBad) begin
            state_d = itoa_pkg::StBad;
          end else if (in_i.radix == itoa_pkg::RadixRaw) begin
            state_d = itoa_pkg::StRaw;
          end else if (is_neg) begin
            state_d = itoa_pkg::StSign;
          end else begin
            state_d = itoa_pkg::StStart;
          end
        end
      end
      itoa_pkg::StBad: begin
        if (out_free) state_d = itoa_pkg::StIdle;
      end
      itoa_pkg::StRaw: begin
        if (out_free) state_d = nl_q ? itoa_pkg::StCr : itoa_pkg::StIdle;
      end
      itoa_pkg::StSign: begin
        if (out_free) state_d = itoa_pkg::StStart;
      end
      itoa_pkg::StStart: begin
        state_d = itoa_pkg::StDiv;
      end
      itoa_pkg::StDiv: begin
        if (div_rsp_i.done) state_d = more_div ? itoa_pkg::StStart : itoa_pkg::StPop;
      end
      itoa_pkg::StPop: begin
        state_d = itoa_pkg::StDigit;
      end
      itoa_pkg::StDigit: begin
        if (out_free) begin
          if (nd_q != '0) begin
            state_d = itoa_pkg::StPop;
          end else begin
            state_d = nl_q ? itoa_pkg::StCr : itoa_pkg::StIdle;
          end
        end
      end
      itoa_pkg::StCr: begin
        if (out_free) state_d = itoa_pkg::StLf;
      end
      itoa_pkg::StLf: begin
        if (out_free) state_d = itoa_pkg::StIdle;
      end
      default: state_d = itoa_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_rdy    = 1'b0;
    emit      = 1'b0;
    emit_char = itoa_pkg::ChNull;
    emit_last = 1'b0;
    emit_bad  = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      itoa_pkg::StIdle: begin
        in_rdy = 1'b1;
      end
      itoa_pkg::StBad: begin
        emit      = out_free;
        emit_last = 1'b1;
        emit_bad  = 1'b1;
      end
      itoa_pkg::StRaw: begin
        emit      = out_free;
        emit_char = val_q[itoa_pkg::CharWidth-1:0];
        emit_last = !nl_q;
      end
      itoa_pkg::StSign: begin
        emit      = out_free;
        emit_char = itoa_pkg::ChMinus;
      end
      itoa_pkg::StStart: begin
        div_start = 1'b1;
      end
      itoa_pkg::StDiv: begin
        push = div_rsp_i.done;
      end
      itoa_pkg::StPop: begin
        pop = 1'b1;
      end
      itoa_pkg::StDigit: begin
        emit      = out_free;
        emit_char = itoa_pkg::digit_char(rd_q);
        emit_last = (nd_q == '0) && !nl_q;
      end
      itoa_pkg::StCr: begin
        emit      = out_free;
        emit_char = itoa_pkg::ChCr;
      end
      itoa_pkg::StLf: begin
        emit      = out_free;
        emit_char = itoa_pkg::ChLf;
        emit_last = 1'b1;
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::StIdle;
      oval_q  <= 1'b0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        oval_q <= 1'b1;
      end else if (out_o.ready) begin
        oval_q <= 1'b0;
      end
      if (accept) begin
        nd_q <= '0;
      end else if (push) begin
        nd_q <= nd_q + 1'b1;
      end else if (pop) begin
        nd_q <= nd_dec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q   <= mag;
      radix_q <= in_i.radix;
      nl_q    <= in_i.append_newline;
    end else if (push) begin
      val_q <= div_rsp_i.quotient;
    end
    if (emit) begin
      char_q <= emit_char;
      last_q <= emit_last;
      bad_q  <= emit_bad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      dig_mem[nd_q[itoa_pkg::DigAddrWidth-1:0]] <= div_rsp_i.remainder;
    end
    if (pop) begin
      rd_q <= dig_mem[nd_dec[itoa_pkg::DigAddrWidth-1:0]];
    end
  end

  assign in_i.ready = in_rdy;

  assign out_o.valid     = oval_q;
  assign out_o.char_out  = char_q;
  assign out_o.last      = last_q;
  assign out_o.bad_radix = bad_q;

  assign div_req_o.start    = div_start;
  assign div_req_o.dividend = val_q;
  assign div_req_o.divisor  = radix_q;

endmodule

// File: sv/integer_radix_to_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_radix_to_ascii_core
// Converts a number word to ASCII digits in base 2..63, raw byte or error.
//
//   channel  dir  payload                                     accepted when
//   in_i     in   value, is_signed, radix, append_newline    valid && ready
//   out_o    out  char_out, last, bad_radix                  valid && ready
//
// One number word at a time; in_i.ready is high only while idle.
// Each digit takes a pass through the shared bit-serial divider (load, 32
// shift/subtract steps, write-back), then a pop and an emit.
// Raw byte, sign, CR and LF are one character word each; base one gives a single error word.
// A stalled out_o holds the sequencer at the next character.
// Reset clears control only; the digit stack needs no clearing.
// ----------------------------------------------------------------------------
module integer_radix_to_ascii_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);

  itoa_pkg::div_req_t div_req;
  itoa_pkg::div_rsp_t div_rsp;

  itoa_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp)
  );

  itoa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_rsp.done)
    else $error("divider done right after start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !in_i.ready)
    else $error("input ready while a division starts");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.bad_radix) |-> (out_o.last && out_o.char_out == '0))
    else $error("bad radix word is not a final zero");
`endif

endmodule

// File: test/integer_radix_to_ascii_checker.sv
// ----------------------------------------------------------------------------
// integer_radix_to_ascii_checker
// Watches the number and character channels of the integer to ASCII core,
// predicts the character words of every accepted number word and compares
// them in order, field by field, with the words the core sends.
// ----------------------------------------------------------------------------
module integer_radix_to_ascii_checker
  import itoa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  itoa_in_if   num_ch,
  itoa_out_if  chr_ch,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [CharWidth-1:0] char_out;
    logic                 last;
    logic                 bad_radix;
  } char_word_t;

  char_word_t expected_chars[$];
  int         fails = 0;

  function automatic void predict_chars(input logic [ValueWidth-1:0] value,
                                        input logic                  is_signed,
                                        input logic [RadixWidth-1:0] radix,
                                        input logic                  append_newline);
    char_word_t            words[$];
    char_word_t            w;
    logic [ValueWidth-1:0] mag;
    logic [RadixWidth-1:0] digs[MaxDigits];
    int                    nd;
    mag = value;
    nd  = 0;
    w   = '0;
    if (radix == RadixBad) begin
      w.bad_radix = 1'b1;
      w.last      = 1'b1;
      expected_chars.push_back(w);
      return;
    end
    if (radix == RadixRaw) begin
      w.char_out = value[CharWidth-1:0];
      words.push_back(w);
    end else begin
      if (radix == RadixDec && is_signed && value[ValueWidth-1]) begin
        w.char_out = ChMinus;
        words.push_back(w);
        mag = -value;
      end
      if (mag == '0) begin
        w.char_out = ChZero;
        words.push_back(w);
      end else begin
        while (mag != '0 && nd < MaxDigits) begin
          digs[nd] = RadixWidth'(mag % ValueWidth'(radix));
          mag      = mag / ValueWidth'(radix);
          nd++;
        end
        while (nd > 0) begin
          nd--;
          w.char_out = (digs[nd] < RadixDec) ? CharWidth'(digs[nd]) + ChZero
                                             : CharWidth'(digs[nd]) + ChAlphaBase;
          words.push_back(w);
        end
      end
    end
    if (append_newline) begin
      w.char_out = ChCr;
      words.push_back(w);
      w.char_out = ChLf;
      words.push_back(w);
    end
    words[words.size()-1].last = 1'b1;
    foreach (words[i]) expected_chars.push_back(words[i]);
  endfunction

  always @(posedge clk_i) begin
    char_word_t want;
    if (rst_ni) begin
      if (num_ch.valid && num_ch.ready)
        predict_chars(num_ch.value, num_ch.is_signed, num_ch.radix, num_ch.append_newline);
      if (chr_ch.valid && chr_ch.ready) begin
        if (expected_chars.size() == 0) begin
          fails++;
          $display("%0t: unexpected word char_out=%h last=%b bad_radix=%b", $time,
                   chr_ch.char_out, chr_ch.last, chr_ch.bad_radix);
        end else begin
          want = expected_chars.pop_front();
          if (chr_ch.char_out !== want.char_out) begin
            fails++;
            $display("%0t: char_out expected %h actual %h", $time, want.char_out,
                     chr_ch.char_out);
          end
          if (chr_ch.last !== want.last) begin
            fails++;
            $display("%0t: last expected %b actual %b", $time, want.last, chr_ch.last);
          end
          if (chr_ch.bad_radix !== want.bad_radix) begin
            fails++;
            $display("%0t: bad_radix expected %b actual %b", $time, want.bad_radix,
                     chr_ch.bad_radix);
          end
        end
      end
    end
    pending_o    <= expected_chars.size();
    fail_count_o <= fails;
  end

endmodule

// File: test/integer_radix_to_ascii_core_tb.sv
// ----------------------------------------------------------------------------
// integer_radix_to_ascii_core_tb
// Drives number words into the integer to ASCII core: directed corner cases
// first, then random words in bursts against a stalling receiver. A checker
// beside the core predicts and compares every character word.
// ----------------------------------------------------------------------------
module integer_radix_to_ascii_core_tb;
  import itoa_pkg::*;

  localparam int NumRandom  = 400;
  localparam int CycleLimit = 4_000_000;

  typedef enum logic [1:0] {
    SinkFree,
    SinkCoin,
    SinkLongStall
  } sink_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         burst_left = 0;
  sink_mode_e sink_mode = SinkFree;
  int         mode_left = 0;
  int         hold_left = 0;

  itoa_in_if  num_ch ();
  itoa_out_if chr_ch ();

  integer_radix_to_ascii_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (num_ch),
    .out_o  (chr_ch)
  );

  integer_radix_to_ascii_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_ch       (num_ch),
    .chr_ch       (chr_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: switch between free, coin-flip and long-stall patterns at random
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      sink_mode <= sink_mode_e'($urandom_range(0, 2));
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      chr_ch.ready <= 1'b0;
    end else begin
      case (sink_mode)
        SinkFree: chr_ch.ready <= 1'b1;
        SinkCoin: chr_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            hold_left    <= $urandom_range(1, 20);
            chr_ch.ready <= 1'b0;
          end else begin
            chr_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic send_number(input logic [ValueWidth-1:0] value, input logic is_signed,
                             input logic [RadixWidth-1:0] radix, input logic nl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        num_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    num_ch.valid          <= 1'b1;
    num_ch.value          <= value;
    num_ch.is_signed      <= is_signed;
    num_ch.radix          <= radix;
    num_ch.append_newline <= nl;
    @(posedge clk_i);
    while (!num_ch.ready) @(posedge clk_i);
  endtask

  initial begin
    logic [ValueWidth-1:0] value;
    logic [RadixWidth-1:0] radix;
    int                    pick;
    rst_ni                <= 1'b0;
    num_ch.valid          <= 1'b0;
    num_ch.value          <= '0;
    num_ch.is_signed      <= 1'b0;
    num_ch.radix          <= RadixRaw;
    num_ch.append_newline <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_number(32'h0000_00A5, 1'b0, RadixRaw, 1'b0);
    send_number(32'hFFFF_FF00, 1'b0, RadixRaw, 1'b1);
    send_number(32'h0123_45FF, 1'b1, RadixRaw, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0, RadixBad, 1'b1);
    send_number(32'h0000_0000, 1'b1, RadixBad, 1'b0);
    send_number(32'h0000_0000, 1'b0, RadixDec, 1'b1);
    send_number(32'hFFFF_FFFF, 1'b0, RadixDec, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b1, RadixDec, 1'b0);
    send_number(32'h8000_0000, 1'b1, RadixDec, 1'b1);
    send_number(32'h7FFF_FFFF, 1'b1, RadixDec, 1'b1);
    send_number(32'hFFFF_FFFF, 1'b0, 6'd2, 1'b1);
    send_number(32'h0000_0001, 1'b1, 6'd2, 1'b0);
    send_number(32'hDEAD_BEEF, 1'b1, 6'd16, 1'b1);
    send_number(32'hFFFF_FFFF, 1'b0, 6'd36, 1'b0);
    send_number(32'd35, 1'b0, 6'd36, 1'b1);
    send_number(32'd62, 1'b0, 6'd63, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1);
    send_number(32'h0000_0000, 1'b1, 6'd3, 1'b0);
    send_number(32'h8000_0000, 1'b1, 6'd8, 1'b0);
    send_number(32'd36, 1'b0, 6'd37, 1'b1);

    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       radix = RadixRaw;
      else if (pick < 13) radix = RadixBad;
      else if (pick < 30) radix = RadixDec;
      else if (pick < 38) radix = 6'd16;
      else if (pick < 43) radix = 6'd2;
      else if (pick < 53) radix = RadixWidth'($urandom_range(37, 63));
      else                radix = RadixWidth'($urandom_range(3, 36));
      case ($urandom_range(0, 4))
        0:       value = $urandom;
        1:       value = $urandom_range(0, 40);
        2:       value = -ValueWidth'($urandom_range(1, 1000));
        3:       value = 32'h1 << $urandom_range(0, 31);
        default: value = 32'h8000_0000 ^ ValueWidth'($urandom_range(0, 3))
                         ^ {ValueWidth{1'($urandom_range(0, 1))}};
      endcase
      send_number(value, 1'($urandom_range(0, 1)), radix, 1'($urandom_range(0, 1)));
    end

    num_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
